FILE: rtl/fxa_pkg.sv
// Package for the Q24.8 fixed-point ALU: commands and widths.
// Depends on nothing.
`timescale 1ns / 1ps
package fxa_pkg;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int DATA_WIDTH_DEF    = 32;
  localparam int CMD_W             = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_LT  = 4'd4, CMD_GT  = 4'd5, CMD_LE  = 4'd6, CMD_GE  = 4'd7,
    CMD_EQ  = 4'd8, CMD_NE  = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
    CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_TOINT = 4'd14, CMD_FROMINT = 4'd15
  } cmd_t;
endpackage

FILE: rtl/fxa_if.sv
// Valid/ready channel interfaces for the fixed-point ALU.
// Depends on fxa_pkg.
`timescale 1ns / 1ps
interface fxa_in_if #(parameter int DW = 32) (input logic clk);
  import fxa_pkg::*;
  logic          valid;
  logic          ready;
  logic [CMD_W-1:0] command;
  logic signed [DW-1:0] operand_a;
  logic signed [DW-1:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface fxa_out_if #(parameter int DW = 32) (input logic clk);
  logic          valid;
  logic          ready;
  logic signed [DW-1:0] result;
  logic          condition;
  logic          overflow;
  logic          divide_by_zero;
  modport source (output valid, result, condition, overflow, divide_by_zero, input ready);
  modport sink   (input valid, result, condition, overflow, divide_by_zero, output ready);
endinterface

FILE: rtl/fixed_point_q24_8_alu.sv
// Top level of the fixed-point ALU: input decode, multiplier, row of
// division cells and output stage. Depends on fxa_pkg, fxa_if, fxa_cell.
`timescale 1ns / 1ps
// Usage: items enter on the in channel (command, operand_a, operand_b) and
// leave on the out channel (result, condition, overflow, divide_by_zero).
// Every item travels the same pipeline, so results leave in order.
// Pipeline: one input register, one cell per quotient bit in the division
// row, and one output register.
// Throughput: one item per cycle unless stalled; the pipeline moves as a whole.
// Stall: when the receiver holds ready low and the last stage is full, the
// whole pipeline holds and in_ready drops; an empty last stage still lets
// the pipeline advance, so a bubble there does not block it.
// Reset: rst_n clears every stage valid bit; payloads need no reset.
// The multiply is a single DW x DW product registered once, feeding a round
// stage; add/sub/compare work is done in the first stage and carried along.
module fixed_point_q24_8_alu #(
  parameter int FRACTION_BITS = fxa_pkg::FRACTION_BITS_DEF,
  parameter int DATA_WIDTH    = fxa_pkg::DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  fxa_in_if.sink    in_ch,
  fxa_out_if.source out_ch
);
  import fxa_pkg::*;
  localparam int DW = DATA_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int NW = DW + FB;        // dividend bits
  localparam int NC = NW;             // one cell per quotient bit
  localparam int SW = DW + CMD_W + 2; // side: result, cmd, cond, ovf

  // pipeline enable: advance unless the last stage is full and stalled
  logic adv;
  logic vld_r [NC+2];
  assign adv = !vld_r[NC+1] || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- stage 0: decode, simple ops, magnitudes
  logic [DW-1:0] a, b, ma, mb, res0;
  logic na, nb, cond0, ovf0;
  logic [CMD_W-1:0] cmd;
  logic lt_ab, lt_ba;
  logic [DW-1:0] y, sm;
  logic sub;
  assign a = in_ch.operand_a;
  assign b = in_ch.operand_b;
  assign cmd = in_ch.command;
  assign na = a[DW-1];
  assign nb = b[DW-1];
  assign ma = na ? (~a + 1'b1) : a;
  assign mb = nb ? (~b + 1'b1) : b;
  assign lt_ab = $signed(a) < $signed(b);
  assign lt_ba = $signed(b) < $signed(a);
  assign sub = (cmd == CMD_SUB) || (cmd == CMD_DEC);
  assign y = ((cmd == CMD_INC) || (cmd == CMD_DEC)) ? {{(DW-1){1'b0}}, 1'b1} : b;
  assign sm = sub ? (a - y) : (a + y);

  always_comb begin
    logic [DW-1:0] m;
    logic [DW-1:0] fi;
    res0 = '0; cond0 = 1'b0; ovf0 = 1'b0;
    m  = ma >> FB;
    fi = a << FB;
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        res0 = sm;
        ovf0 = (sub ? (a[DW-1] != y[DW-1]) : (a[DW-1] == y[DW-1]))
               && (sm[DW-1] != a[DW-1]);
      end
      CMD_LT: cond0 = lt_ab;
      CMD_GT: cond0 = lt_ba;
      CMD_LE: cond0 = !lt_ba;
      CMD_GE: cond0 = !lt_ab;
      CMD_EQ: cond0 = (a == b);
      CMD_NE: cond0 = (a != b);
      CMD_MIN: res0 = lt_ab ? a : b;
      CMD_MAX: res0 = lt_ba ? a : b;
      CMD_TOINT: res0 = na ? (~m + 1'b1) : m;
      CMD_FROMINT: begin
        res0 = fi;
        ovf0 = ($signed(fi) >>> FB) != $signed(a);
      end
      default: ;
    endcase
  end

  // stage 1 registers
  logic [DW-1:0] ma_r, mb_r;
  logic neg_r;
  logic [SW-1:0] side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_ch.valid;
    if (adv) begin
      ma_r   <= ma;
      mb_r   <= mb;
      neg_r  <= na ^ nb;
      side_r <= {res0, cmd, cond0, ovf0};
    end
  end

  // ---- multiplier: product register, then carried as a side value
  logic [2*DW-1:0] prod_r;
  always_ff @(posedge clk) if (adv) prod_r <= ma_r * mb_r;

  // ---- division cell row
  logic [NW-1:0] num_w [NC+1];
  logic [DW:0]   rem_w [NC+1];
  logic [DW-1:0] den_w [NC+1];
  logic [NW-1:0] quo_w [NC+1];
  logic [SW-1:0] sid_w [NC+1];
  assign num_w[0] = {ma_r, {FB{1'b0}}};
  assign rem_w[0] = '0;
  assign den_w[0] = mb_r;
  assign quo_w[0] = '0;
  assign sid_w[0] = side_r;

  // neg flag and product travel beside the cells
  logic neg_d [NC+1];
  logic [2*DW-1:0] prod_d [NC];
  assign neg_d[0] = neg_r;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fxa_cell #(.DW(DW), .NW(NW)) u_cell (
      .clk(clk), .en(adv),
      .num_i(num_w[i]), .rem_i(rem_w[i]), .den_i(den_w[i]),
      .quo_i(quo_w[i]), .side_i(sid_w[i]),
      .num_o(num_w[i+1]), .rem_o(rem_w[i+1]), .den_o(den_w[i+1]),
      .quo_o(quo_w[i+1]), .side_o(sid_w[i+1])
    );
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i+1] <= 1'b0;
      else if (adv) vld_r[i+1] <= vld_r[i];
      if (adv) neg_d[i+1] <= neg_d[i];
    end
    if (i == 0) begin : g_p0
      assign prod_d[0] = prod_r;
    end else begin : g_pn
      always_ff @(posedge clk) if (adv) prod_d[i] <= prod_d[i-1];
    end
  end

  // ---- round stage: mul and div rounding and range check
  logic [SW-1:0] sd;
  logic [CMD_W-1:0] cmd_e;
  logic [DW-1:0] den_e;
  logic [DW:0]   rem_e;
  logic [2*DW:0] pr;
  logic [NW:0]   qr;
  logic [2*DW:0] mag;
  logic [DW-1:0] res_e;
  logic cond_e, ovf_e, dz_e, neg_e, big;
  assign sd    = sid_w[NC];
  assign cmd_e = sd[CMD_W+1:2];
  assign den_e = den_w[NC];
  assign rem_e = rem_w[NC];
  assign neg_e = neg_d[NC];
  assign pr = ({1'b0, prod_d[NC-1]} + ((2*DW+1)'(1) << (FB-1))) >> FB;
  assign qr = {1'b0, quo_w[NC]} +
              (NW+1)'(({rem_e, 1'b0}) >= {2'b00, den_e});

  always_comb begin
    res_e  = sd[SW-1:CMD_W+2];
    cond_e = sd[1];
    ovf_e  = sd[0];
    dz_e   = 1'b0;
    mag    = '0;
    big    = 1'b0;
    if ((cmd_e == CMD_MUL) || (cmd_e == CMD_DIV)) begin
      mag = (cmd_e == CMD_MUL) ? pr : (2*DW+1)'(qr);
      big = neg_e ? (mag > ((2*DW+1)'(1) << (DW-1)))
                  : (mag > (((2*DW+1)'(1) << (DW-1)) - 1'b1));
      res_e = neg_e ? (~mag[DW-1:0] + 1'b1) : mag[DW-1:0];
      ovf_e = big;
      if ((cmd_e == CMD_DIV) && (den_e == '0)) begin
        res_e = '0; ovf_e = 1'b0; dz_e = 1'b1;
      end
    end
  end

  // ---- output registers
  logic [DW-1:0] res_r;
  logic cond_r, ovf_r, dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[NC+1] <= 1'b0;
    else if (adv) vld_r[NC+1] <= vld_r[NC];
    if (adv) begin
      res_r <= res_e; cond_r <= cond_e; ovf_r <= ovf_e; dz_r <= dz_e;
    end
  end

  assign out_ch.valid          = vld_r[NC+1];
  assign out_ch.result         = res_r;
  assign out_ch.condition      = cond_r;
  assign out_ch.overflow       = ovf_r;
  assign out_ch.divide_by_zero = dz_r;

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.result))
    else $error("result changed under stall");
  // flags are exclusive per command class
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.divide_by_zero && out_ch.overflow))
    else $error("overflow with divide by zero");
  a_dz0: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.divide_by_zero |-> out_ch.result == '0)
    else $error("divide by zero result not zero");
endmodule

FILE: rtl/fxa_cell.sv
// One restoring-division cell: a quotient bit per cycle while en is high,
// carrying the item payload along. Depends on fxa_pkg.
`timescale 1ns / 1ps
module fxa_cell #(
  parameter int DW = 32,
  parameter int NW = 40
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW:0]   rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [NW-1:0] quo_i,
  input  logic [DW+fxa_pkg::CMD_W+1:0] side_i,
  output logic [NW-1:0] num_o,
  output logic [DW:0]   rem_o,
  output logic [DW-1:0] den_o,
  output logic [NW-1:0] quo_o,
  output logic [DW+fxa_pkg::CMD_W+1:0] side_o
);
  import fxa_pkg::*;
  logic [DW+1:0] sh;
  logic [DW+1:0] df;
  assign sh = {rem_i, num_i[NW-1]};
  assign df = sh - {2'b00, den_i};
  always_ff @(posedge clk) begin
    if (en) begin
      num_o  <= {num_i[NW-2:0], 1'b0};
      den_o  <= den_i;
      side_o <= side_i;
      if (!df[DW+1]) begin
        rem_o <= df[DW:0];
        quo_o <= {quo_i[NW-2:0], 1'b1};
      end else begin
        rem_o <= sh[DW:0];
        quo_o <= {quo_i[NW-2:0], 1'b0};
      end
    end
  end
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for fixed_point_q24_8_alu: a directed table followed by
// random items, with every result checked against its table row or a built-in
// predictor. Depends on fxa_pkg, fxa_if and the RTL top level.
`timescale 1ns / 1ps
module tb;
  import fxa_pkg::*;

  localparam int FB          = FRACTION_BITS_DEF;
  localparam int DW          = DATA_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1380;
  localparam int LATENCY     = DW + FB + 1;
  localparam int IDLE_LIMIT  = 3000;   // longest stall plus latency, several times over
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [DW-1:0] result;
    logic          condition;
    logic          overflow;
    logic          divide_by_zero;
  } alu_res_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
    logic          typed;
    alu_res_t      want;
  } stim_row_t;

  localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] MINN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] ONE  = DW'(1) << FB;

  logic clk;
  logic rst_n;

  fxa_in_if  #(.DW(DW)) in_ch  (clk);
  fxa_out_if #(.DW(DW)) out_ch (clk);

  fixed_point_q24_8_alu uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_res_t pending_q[$];
  int       errors = 0;
  int       sent = 0;
  int       checked = 0;
  int       cmd_seen[16];
  bit       stim_done = 0;
  bit       hold_done = 0;
  int       idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Exact fixed-point behavior, independent of the pipeline.
  function automatic alu_res_t predict_alu(cmd_t c, logic signed [DW-1:0] a,
                                           logic signed [DW-1:0] b);
    alu_res_t o;
    logic signed [DW:0]   s;
    logic signed [DW-1:0] y;
    logic [DW-1:0]        ma;
    logic [DW-1:0]        mb;
    logic [2*DW-1:0]      p;
    logic [2*DW-1:0]      q;
    logic [2*DW-1:0]      r;
    logic [2*DW-1:0]      mag;
    logic [DW-1:0]        w;
    logic                 neg;
    bit                   rounded;
    o = '0;
    rounded = 0;
    mag = '0;
    ma = a[DW-1] ? DW'(-a) : a;
    mb = b[DW-1] ? DW'(-b) : b;
    neg = a[DW-1] ^ b[DW-1];
    case (c)
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        y = (c == CMD_INC || c == CMD_DEC) ? DW'(1) : b;
        if (c == CMD_SUB || c == CMD_DEC) s = $signed({a[DW-1], a}) - $signed({y[DW-1], y});
        else s = $signed({a[DW-1], a}) + $signed({y[DW-1], y});
        o.result = s[DW-1:0];
        o.overflow = s[DW] != s[DW-1];
      end
      CMD_MUL: begin
        p = (2*DW)'(ma) * (2*DW)'(mb);
        mag = (p + ((2*DW)'(1) << (FB - 1))) >> FB;
        rounded = 1;
      end
      CMD_DIV: begin
        if (b == '0) o.divide_by_zero = 1'b1;
        else begin
          q = ((2*DW)'(ma) << FB) / (2*DW)'(mb);
          r = ((2*DW)'(ma) << FB) % (2*DW)'(mb);
          // round half away from zero on the magnitude
          if (r >= (2*DW)'(mb) - r) q = q + 1;
          mag = q;
          rounded = 1;
        end
      end
      CMD_LT: o.condition = a < b;
      CMD_GT: o.condition = b < a;
      CMD_LE: o.condition = !(b < a);
      CMD_GE: o.condition = !(a < b);
      CMD_EQ: o.condition = a == b;
      CMD_NE: o.condition = a != b;
      CMD_MIN: o.result = (a < b) ? a : b;
      CMD_MAX: o.result = (b < a) ? a : b;
      CMD_TOINT: begin
        w = ma >> FB;
        o.result = a[DW-1] ? DW'(-w) : w;
      end
      default: begin
        o.result = a <<< FB;
        o.overflow = ($signed(o.result) >>> FB) != a;
      end
    endcase
    if (rounded) begin
      o.overflow = neg ? (mag > (2*DW)'(MINN)) : (mag > (2*DW)'(MAXP));
      o.result = neg ? DW'(-mag[DW-1:0]) : mag[DW-1:0];
    end
    return o;
  endfunction

  // Bias operands toward the edges of the range and toward small magnitudes.
  function automatic logic [DW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MAXP;
      1: return MINN;
      2: return '0;
      3: return {DW{1'b1}};
      4: return DW'($urandom_range(0, 4095));
      5: return -DW'($urandom_range(0, 4095));
      6: return DW'($signed($urandom) >>> $urandom_range(8, 28));
      default: return DW'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the block takes it; record the expectation.
  task automatic send_item(cmd_t c, logic [DW-1:0] a, logic [DW-1:0] b,
                           logic typed, alu_res_t want);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= c;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(typed ? want : predict_alu(c, a, b));
    cmd_seen[c]++;
    sent++;
  endtask

  task automatic idle_gap(int n);
    in_ch.valid <= 1'b0;
    in_ch.command   <= cmd_t'($urandom_range(0, 15));
    in_ch.operand_a <= DW'($urandom);
    in_ch.operand_b <= DW'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // Sender: directed table, then random bursts with random gaps.
  initial begin
    stim_row_t rows[] = '{
      '{CMD_ADD,     '0,      '0,      1'b1, '{'0,    1'b0, 1'b0, 1'b0}},
      '{CMD_ADD,     MAXP,    DW'(1),  1'b1, '{MINN,  1'b0, 1'b1, 1'b0}},
      '{CMD_SUB,     MINN,    DW'(1),  1'b1, '{MAXP,  1'b0, 1'b1, 1'b0}},
      '{CMD_MUL,     ONE,     ONE,     1'b1, '{ONE,   1'b0, 1'b0, 1'b0}},
      '{CMD_MUL,     MINN,    MINN,    1'b0, '0},
      '{CMD_MUL,     DW'(8'h80), DW'(1), 1'b0, '0},
      '{CMD_MUL,     -DW'(8'h80), DW'(1), 1'b0, '0},
      '{CMD_DIV,     ONE,     '0,      1'b1, '{'0,    1'b0, 1'b0, 1'b1}},
      '{CMD_DIV,     MINN,    {DW{1'b1}}, 1'b0, '0},
      '{CMD_DIV,     ONE,     3*ONE,   1'b0, '0},
      '{CMD_LT,      MINN,    MAXP,    1'b1, '{'0,    1'b1, 1'b0, 1'b0}},
      '{CMD_GT,      MINN,    MAXP,    1'b1, '{'0,    1'b0, 1'b0, 1'b0}},
      '{CMD_LE,      DW'(5),  DW'(5),  1'b1, '{'0,    1'b1, 1'b0, 1'b0}},
      '{CMD_GE,      {DW{1'b1}}, '0,   1'b1, '{'0,    1'b0, 1'b0, 1'b0}},
      '{CMD_EQ,      DW'(5),  DW'(5),  1'b1, '{'0,    1'b1, 1'b0, 1'b0}},
      '{CMD_NE,      DW'(5),  DW'(5),  1'b1, '{'0,    1'b0, 1'b0, 1'b0}},
      '{CMD_MIN,     MINN,    MAXP,    1'b1, '{MINN,  1'b0, 1'b0, 1'b0}},
      '{CMD_MAX,     MINN,    MAXP,    1'b1, '{MAXP,  1'b0, 1'b0, 1'b0}},
      '{CMD_MIN,     DW'(3),  DW'(3),  1'b1, '{DW'(3), 1'b0, 1'b0, 1'b0}},
      '{CMD_INC,     MAXP,    DW'(7),  1'b1, '{MINN,  1'b0, 1'b1, 1'b0}},
      '{CMD_DEC,     MINN,    MAXP,    1'b1, '{MAXP,  1'b0, 1'b1, 1'b0}},
      '{CMD_TOINT,   -ONE,    '0,      1'b1, '{{DW{1'b1}}, 1'b0, 1'b0, 1'b0}},
      '{CMD_TOINT,   -DW'(8'h80), '0,  1'b1, '{'0,    1'b0, 1'b0, 1'b0}},
      '{CMD_FROMINT, DW'(1),  '0,      1'b1, '{ONE,   1'b0, 1'b0, 1'b0}},
      '{CMD_FROMINT, MINN >> FB, '0,   1'b1, '{MINN,  1'b0, 1'b1, 1'b0}}
    };
    int burst;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_ADD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
    end

    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++, n++)
        send_item(cmd_t'($urandom_range(0, 15)), pick_operand(), pick_operand(), 1'b0, '0);
      // drain completely once, midway, after the long receiver hold-off
      if (n >= RANDOM_ITEMS / 2 && hold_done) begin
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        hold_done = 0;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
    in_ch.valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random stall pattern plus one long hold-off so the pipeline fills.
  initial begin
    int cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 600) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1;
      end else if ((cyc / 64) % 3 == 0) begin
        out_ch.ready <= 1'b1;               // stretch with no stalls
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result %h", out_ch.result);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        checked++;
        if (out_ch.result !== exp_r.result) begin
          $error("result: expected %h, got %h", exp_r.result, out_ch.result);
          errors++;
        end
        if (out_ch.condition !== exp_r.condition) begin
          $error("condition: expected %b, got %b", exp_r.condition, out_ch.condition);
          errors++;
        end
        if (out_ch.overflow !== exp_r.overflow) begin
          $error("overflow: expected %b, got %b", exp_r.overflow, out_ch.overflow);
          errors++;
        end
        if (out_ch.divide_by_zero !== exp_r.divide_by_zero) begin
          $error("divide_by_zero: expected %b, got %b",
                 exp_r.divide_by_zero, out_ch.divide_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_q.size());
      $display("tb failed");
      $finish;
    end
  end

  // Wrap up once stimulus is done and every expected result has arrived.
  initial begin
    wait (stim_done);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d items sent, %0d results checked, %0d mismatches", sent, checked, errors);
    $display("commands add..fromint: %p", cmd_seen);
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end
endmodule
